// ===== hw/rtl/dspw_pkg.sv =====
// dspw_pkg: shared types, character codes and calendar helpers for the
// date string parser with weekday output
// no dependencies
package dspw_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned DayW        = 5;
  localparam int unsigned MonthW      = 4;
  localparam int unsigned YearOutW    = 16;
  localparam int unsigned WdayW       = 3;
  localparam int unsigned HeldW       = 16;
  localparam int unsigned ModW        = 9;
  localparam int unsigned YearBitsDef = 16;
  localparam int unsigned InTdataW    = 8;
  localparam int unsigned OutTdataW   = 32;

  localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CharW-1:0] CHAR_SEP   = 8'h2E;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CharW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CharW-1:0] CHAR_CR    = 8'h0D;

  typedef enum logic [1:0] {
    FIELD_DAY   = 2'd0,
    FIELD_MONTH = 2'd1,
    FIELD_YEAR  = 2'd2
  } field_e;

  // closed fields and status seen by the date check
  typedef struct packed {
    field_e              index;
    logic                bad;
    logic [HeldW-1:0]    held_day;
    logic [HeldW-1:0]    held_month;
    logic [ModW-1:0]     year_mod;
  } parse_view_t;

  typedef struct packed {
    logic                ok;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [YearOutW-1:0] year;
    logic [WdayW-1:0]    wday;
  } result_t;

  // (r * 10 + digit) mod 400 for r below 400
  function automatic logic [ModW-1:0] mod400_step(input logic [ModW-1:0] r,
                                                   input logic [3:0] digit);
    logic [11:0] v;
    logic [11:0] rem;
    v   = 12'({r, 3'b000}) + 12'({r, 1'b0}) + 12'(digit);
    rem = v;
    for (int i = 1; i <= 9; i++) begin
      if (v >= 12'(i * 400)) begin
        rem = v - 12'(i * 400);
      end
    end
    return rem[ModW-1:0];
  endfunction

  // x mod 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [10:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  function automatic logic [2:0] month_key(input logic [MonthW-1:0] m);
    logic [2:0] k;
    unique case (m)
      4'd1:    k = 3'd0;
      4'd2:    k = 3'd3;
      4'd3:    k = 3'd2;
      4'd4:    k = 3'd5;
      4'd5:    k = 3'd0;
      4'd6:    k = 3'd3;
      4'd7:    k = 3'd5;
      4'd8:    k = 3'd1;
      4'd9:    k = 3'd4;
      4'd10:   k = 3'd6;
      4'd11:   k = 3'd2;
      4'd12:   k = 3'd4;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] month_len(input logic [HeldW-1:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      16'd2:                                 len = leap ? 5'd29 : 5'd28;
      16'd4, 16'd6, 16'd9, 16'd11:           len = 5'd30;
      16'd1, 16'd3, 16'd5, 16'd7, 16'd8,
      16'd10, 16'd12:                        len = 5'd31;
      default:                               len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/dspw_parse.sv =====
// dspw_parse: per-character field scanner holding the parse state
// depends on dspw_pkg
module dspw_parse import dspw_pkg::*; #(
  parameter int unsigned YEAR_BITS = YearBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [CharW-1:0]     char_i,
  output parse_view_t          view_o,
  output logic [YEAR_BITS-1:0] field_value_o
);

  field_e                 index_q, index_d;
  logic [YEAR_BITS-1:0]   value_q, value_d;
  logic [ModW-1:0]        mod_q, mod_d;
  logic                   stopped_q, stopped_d;
  logic                   neg_q, neg_d;
  logic                   started_q, started_d;
  logic [HeldW-1:0]       held_day_q, held_day_d;
  logic [HeldW-1:0]       held_month_q, held_month_d;
  logic                   err_q, err_d;

  logic                   is_digit;
  logic                   is_space;
  logic [3:0]             digit;
  logic [YEAR_BITS+3:0]   acc;
  logic [YEAR_BITS+15:0]  value_ext;
  logic                   value_wide;

  assign is_digit   = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign is_space   = (char_i == CHAR_SPACE) || ((char_i >= CHAR_TAB) && (char_i <= CHAR_CR));
  assign digit      = char_i[3:0];
  assign acc        = (YEAR_BITS + 4)'({value_q, 3'b000}) + (YEAR_BITS + 4)'({value_q, 1'b0}) +
                      (YEAR_BITS + 4)'(digit);
  assign value_ext  = {16'd0, value_q};
  assign value_wide = |value_ext[YEAR_BITS+15:HeldW];

  always_comb begin
    index_d      = index_q;
    value_d      = value_q;
    mod_d        = mod_q;
    stopped_d    = stopped_q;
    neg_d        = neg_q;
    started_d    = started_q;
    held_day_d   = held_day_q;
    held_month_d = held_month_q;
    err_d        = err_q;
    if (en_i) begin
      if (char_i == CHAR_NUL) begin
        index_d      = FIELD_DAY;
        value_d      = '0;
        mod_d        = '0;
        stopped_d    = 1'b0;
        neg_d        = 1'b0;
        started_d    = 1'b0;
        held_day_d   = '0;
        held_month_d = '0;
        err_d        = 1'b0;
      end else if (char_i == CHAR_SEP) begin
        err_d = err_q | neg_q;
        unique case (index_q)
          FIELD_DAY: begin
            held_day_d = value_ext[HeldW-1:0];
            if (value_wide) err_d = 1'b1;
            index_d = FIELD_MONTH;
          end
          FIELD_MONTH: begin
            held_month_d = value_ext[HeldW-1:0];
            if (value_wide) err_d = 1'b1;
            index_d = FIELD_YEAR;
          end
          default: begin
            // surplus field
            err_d = 1'b1;
          end
        endcase
        value_d   = '0;
        mod_d     = '0;
        stopped_d = 1'b0;
        neg_d     = 1'b0;
        started_d = 1'b0;
      end else if (!stopped_q) begin
        priority if (is_digit) begin
          started_d = 1'b1;
          mod_d     = mod400_step(mod_q, digit);
          if (|acc[YEAR_BITS+3:YEAR_BITS]) begin
            value_d = '1;
            err_d   = 1'b1;
          end else begin
            value_d = acc[YEAR_BITS-1:0];
          end
        end else if (!started_q && is_space) begin
          // leading white space skipped
        end else if (!started_q && (char_i == CHAR_PLUS || char_i == CHAR_MINUS)) begin
          started_d = 1'b1;
          neg_d     = (char_i == CHAR_MINUS);
        end else begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q      <= FIELD_DAY;
      value_q      <= '0;
      mod_q        <= '0;
      stopped_q    <= 1'b0;
      neg_q        <= 1'b0;
      started_q    <= 1'b0;
      held_day_q   <= '0;
      held_month_q <= '0;
      err_q        <= 1'b0;
    end else begin
      index_q      <= index_d;
      value_q      <= value_d;
      mod_q        <= mod_d;
      stopped_q    <= stopped_d;
      neg_q        <= neg_d;
      started_q    <= started_d;
      held_day_q   <= held_day_d;
      held_month_q <= held_month_d;
      err_q        <= err_d;
    end
  end

  // a minus sign on the open field also spoils the date at the terminator
  assign view_o.index      = index_q;
  assign view_o.bad        = err_q | neg_q;
  assign view_o.held_day   = held_day_q;
  assign view_o.held_month = held_month_q;
  assign view_o.year_mod   = mod_q;
  assign field_value_o     = value_q;

endmodule

// ===== hw/rtl/dspw_check.sv =====
// dspw_check: gregorian validity check and weekday from the closed fields
// depends on dspw_pkg
module dspw_check import dspw_pkg::*; #(
  parameter int unsigned YEAR_BITS = YearBitsDef
) (
  input  parse_view_t          view_i,
  input  logic [YEAR_BITS-1:0] year_i,
  output result_t              res_o
);

  logic [ModW-1:0]       r;
  logic [ModW-1:0]       q;
  logic [YEAR_BITS+15:0] year_ext;
  logic                  century;
  logic                  leap;
  logic [4:0]            len;
  logic [1:0]            q_hundreds;
  logic [10:0]           wsum;
  logic                  ok;

  assign r        = view_i.year_mod;
  assign year_ext = {16'd0, year_i};
  assign century  = (r == 9'd0) || (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
  assign leap     = ((r[1:0] == 2'b00) && !century) || (r == 9'd0);
  assign len      = month_len(view_i.held_month, leap);

  // the 400-year cycle is a whole number of weeks, so year mod 400 suffices
  always_comb begin
    q = r;
    if (view_i.held_month < 16'd3) begin
      q = (r == 9'd0) ? 9'd399 : r - 9'd1;
    end
    q_hundreds = 2'd0;
    if (q >= 9'd100) q_hundreds = 2'd1;
    if (q >= 9'd200) q_hundreds = 2'd2;
    if (q >= 9'd300) q_hundreds = 2'd3;
  end

  assign wsum = 11'(q) + 11'(q[ModW-1:2]) - 11'(q_hundreds) +
                11'(month_key(view_i.held_month[MonthW-1:0])) +
                11'(view_i.held_day[DayW-1:0]);

  assign ok = !view_i.bad && (view_i.index == FIELD_YEAR) &&
              (view_i.held_month >= 16'd1) && (view_i.held_month <= 16'd12) &&
              (year_i != '0) && (view_i.held_day >= 16'd1) &&
              (view_i.held_day <= 16'(len));

  assign res_o.ok    = ok;
  assign res_o.day   = ok ? view_i.held_day[DayW-1:0] : '0;
  assign res_o.month = ok ? view_i.held_month[MonthW-1:0] : '0;
  assign res_o.year  = ok ? year_ext[YearOutW-1:0] : '0;
  assign res_o.wday  = ok ? mod7(wsum) : '0;

endmodule

// ===== hw/rtl/date_string_parse_weekday.sv =====
// date_string_parse_weekday: one character per transfer, a result on each zero byte
// a zero byte passes the input register and then the output register before its result is on m_axis
// throughput: one character per cycle; the input register waits only when a
// zero byte meets a result that has not been taken yet
// reset clears the valid flags of the input and output registers and all parse state
// depends on dspw_pkg, dspw_parse, dspw_check
module date_string_parse_weekday import dspw_pkg::*; #(
  parameter int unsigned YEAR_BITS = YearBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [7:0] char_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [4:0] day, [8:5] month, [24:9] year,
                                               // [27:25] weekday, [31:28] zero
  output logic                 m_axis_tuser    // [0] valid_res
);

  logic                 in_vld_q, in_vld_d;
  logic [CharW-1:0]     in_char_q;
  logic                 out_vld_q, out_vld_d;
  result_t              res_q;
  result_t              res;
  parse_view_t          view;
  logic [YEAR_BITS-1:0] field_value;
  logic                 s_xfer;
  logic                 proc;
  logic                 finish;

  // a zero byte needs a free output register; other bytes always move on
  assign proc          = in_vld_q && ((in_char_q != CHAR_NUL) || !out_vld_q || m_axis_tready);
  assign finish        = proc && (in_char_q == CHAR_NUL);
  assign s_axis_tready = !in_vld_q || proc;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = s_xfer || (in_vld_q && !proc);
  assign out_vld_d     = finish || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_char_q <= s_axis_tdata[CharW-1:0];
    end
    if (finish) begin
      res_q <= res;
    end
  end

  dspw_parse #(
    .YEAR_BITS (YEAR_BITS)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (proc),
    .char_i        (in_char_q),
    .view_o        (view),
    .field_value_o (field_value)
  );

  dspw_check #(
    .YEAR_BITS (YEAR_BITS)
  ) u_check (
    .view_i (view),
    .year_i (field_value),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.ok;
  assign m_axis_tdata  = {4'd0, res_q.wday, res_q.year, res_q.month, res_q.day};

  // an invalid date carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("invalid result with nonzero fields");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (res_q.month >= 4'd1 && res_q.month <= 4'd12 && res_q.day != '0 && res_q.wday <= 3'd6))
    else $error("valid result out of calendar range");

  a_zero_byte_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && in_char_q == CHAR_NUL && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("zero byte taken over a pending result");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (view.index == FIELD_DAY && !view.bad))
    else $error("parser not back at day field after terminator");

endmodule

// ===== tb/date_string_parse_weekday_chk.sv =====
`timescale 1ns / 100ps
// date_string_parse_weekday_chk: watches both streams of the date parser, predicts
// each result from the accepted characters and compares it field by field
// depends on dspw_pkg
module date_string_parse_weekday_chk import dspw_pkg::*; #(
  parameter int unsigned YEAR_BITS = YearBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [7:0] char_in
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata,   // [4:0] day, [8:5] month, [24:9] year,
                                               // [27:25] weekday, [31:28] zero
  input  logic                 m_axis_tuser,   // [0] valid_res
  output int                   fail_cnt_o,
  output int                   pending_o
);

  localparam logic [31:0] FieldMax = (32'd1 << YEAR_BITS) - 32'd1;

  // parse state of the predictor
  field_e           fld_idx;
  logic [31:0]      fld_val;
  logic             stop_seen;
  logic             neg_seen;
  logic             sign_or_digit;
  logic [HeldW-1:0] day_hold;
  logic [HeldW-1:0] mon_hold;
  logic             bad;

  result_t date_q[$];
  int      fails  = 0;
  int      n_wait = 0;

  assign fail_cnt_o = fails;
  assign pending_o  = n_wait;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_leap(input logic [31:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input logic [HeldW-1:0] m,
                                                input logic [31:0] y);
    case (m)
      16'd2:                          return is_leap(y) ? 29 : 28;
      16'd4, 16'd6, 16'd9, 16'd11:    return 30;
      16'd1, 16'd3, 16'd5, 16'd7,
      16'd8, 16'd10, 16'd12:          return 31;
      default:                        return 0;
    endcase
  endfunction

  // Sakamoto day of week, 0 is Sunday
  function automatic logic [2:0] weekday_of(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    int unsigned yy;
    int unsigned key;
    yy = (m < 3) ? y - 1 : y;
    case (m)
      1, 5:      key = 0;
      2, 6:      key = 3;
      3, 11:     key = 2;
      4, 7:      key = 5;
      8:         key = 1;
      9, 12:     key = 4;
      default:   key = 6;
    endcase
    return 3'((yy + yy / 4 - yy / 100 + yy / 400 + key + d) % 7);
  endfunction

  function automatic void clear_field();
    fld_val       = '0;
    stop_seen     = 1'b0;
    neg_seen      = 1'b0;
    sign_or_digit = 1'b0;
  endfunction

  function automatic void clear_all();
    clear_field();
    fld_idx  = FIELD_DAY;
    day_hold = '0;
    mon_hold = '0;
    bad      = 1'b0;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic [31:0] acc;
    result_t     r;
    logic        ok;
    if (c != CHAR_NUL && c != CHAR_SEP) begin
      if (!stop_seen) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          acc = fld_val * 10 + 32'(c - CHAR_ZERO);
          sign_or_digit = 1'b1;
          if (acc > FieldMax) begin
            fld_val = FieldMax;
            bad     = 1'b1;
          end else begin
            fld_val = acc;
          end
        end else if (!sign_or_digit && is_blank(c)) begin
          // leading blanks skipped
        end else if (!sign_or_digit && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
          sign_or_digit = 1'b1;
          neg_seen      = (c == CHAR_MINUS);
        end else begin
          stop_seen = 1'b1;
        end
      end
      return;
    end

    if (neg_seen) bad = 1'b1;

    if (c == CHAR_SEP) begin
      case (fld_idx)
        FIELD_DAY: begin
          day_hold = fld_val[HeldW-1:0];
          if (fld_val > 32'hFFFF) bad = 1'b1;
          fld_idx = FIELD_MONTH;
        end
        FIELD_MONTH: begin
          mon_hold = fld_val[HeldW-1:0];
          if (fld_val > 32'hFFFF) bad = 1'b1;
          fld_idx = FIELD_YEAR;
        end
        default: bad = 1'b1;   // surplus field
      endcase
      clear_field();
      return;
    end

    ok = !bad && fld_idx == FIELD_YEAR && mon_hold >= 1 && mon_hold <= 12 &&
         fld_val >= 1 && day_hold >= 1 &&
         int'(day_hold) <= int'(days_in_month(mon_hold, fld_val));
    r = '0;
    if (ok) begin
      r.ok    = 1'b1;
      r.day   = day_hold[DayW-1:0];
      r.month = mon_hold[MonthW-1:0];
      r.year  = fld_val[YearOutW-1:0];
      r.wday  = weekday_of(day_hold, mon_hold, fld_val);
    end
    date_q.push_back(r);
    clear_all();
  endfunction

  task automatic cmp_field(input string name, input int unsigned want,
                           input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      clear_all();
      date_q.delete();
    end else begin
      // results first: a zero byte taken in this cycle cannot be answered yet
      if (m_axis_tvalid && m_axis_tready) begin
        if (date_q.size() == 0) begin
          $error("result with nothing expected: tdata %h, tuser %b",
                 m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = date_q.pop_front();
          cmp_field("valid_res", want.ok, m_axis_tuser);
          cmp_field("day", want.day, m_axis_tdata[4:0]);
          cmp_field("month", want.month, m_axis_tdata[8:5]);
          cmp_field("year", want.year, m_axis_tdata[24:9]);
          cmp_field("weekday", want.wday, m_axis_tdata[27:25]);
          cmp_field("pad", 0, m_axis_tdata[31:28]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_char(s_axis_tdata);
      end
    end
    n_wait = date_q.size();
  end

endmodule

// ===== tb/date_string_parse_weekday_tb.sv =====
`timescale 1ns / 100ps
// date_string_parse_weekday_tb: feeds date strings one character per transfer,
// directed cases first and then random ones; depends on dspw_pkg, the parser
// and date_string_parse_weekday_chk
module date_string_parse_weekday_tb;
  import dspw_pkg::*;

  localparam int unsigned YearBits  = YearBitsDef;
  localparam int unsigned RandChars = 960;
  localparam int unsigned TailChars = 200;
  localparam int unsigned Limit     = 300000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  int          fails;
  int          pending;
  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  logic        tx_idle_on = 1'b0;
  logic        rx_idle_on = 1'b0;
  int unsigned rx_hold = 0;
  logic [7:0]  text_q[$];

  always #5 clk_i = ~clk_i;

  date_string_parse_weekday #(
    .YEAR_BITS(YearBits)
  ) uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  date_string_parse_weekday_chk #(
    .YEAR_BITS(YearBits)
  ) chk (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .fail_cnt_o(fails),
    .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls in bursts while rx_idle_on is set
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready = 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(0, 7);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_char(input logic [7:0] c);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic flush_text();
    while (text_q.size() > 0) send_char(text_q.pop_front());
    send_char(CHAR_NUL);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    flush_text();
  endtask

  task automatic add_num(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // one field with occasional blanks, sign, leading zeros and trailing junk
  task automatic add_field(input int unsigned n);
    logic [7:0] j;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        text_q.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                              : 8'(CHAR_TAB + $urandom_range(0, 4)));
      end
    end
    case ($urandom_range(0, 19))
      0:       text_q.push_back(CHAR_MINUS);
      1:       text_q.push_back(CHAR_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_ZERO);
    end
    add_num(n);
    if ($urandom_range(0, 11) == 0) begin
      j = 8'($urandom_range(1, 255));
      if (j == CHAR_SEP) j = CHAR_PLUS;
      text_q.push_back(j);
    end
  endtask

  task automatic send_random_date();
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned kind;
    logic [7:0]  b;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      d = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(0, 32);
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) begin
        m = 2;
        d = $urandom_range(28, 30);
      end
      case ($urandom_range(0, 9))
        0:       y = $urandom_range(0, 3);
        6:       y = 100 * $urandom_range(15, 25);
        7:       y = $urandom_range(9000, 65535);
        8:       y = $urandom_range(65530, 65540);
        9:       y = $urandom_range(65536, 9999999);
        default: y = $urandom_range(1, 2100);
      endcase
      add_field(d);
      text_q.push_back(CHAR_SEP);
      add_field(m);
      text_q.push_back(CHAR_SEP);
      add_field(y);
    end else if (kind == 7) begin
      // raw noise
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(1, 255)));
    end else if (kind == 8) begin
      // too few or too many fields
      y = $urandom_range(0, 5);
      for (int i = 0; i < int'(y); i++) begin
        if (i > 0) text_q.push_back(CHAR_SEP);
        add_num($urandom_range(0, 40));
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 5))
          0:       b = CHAR_SEP;
          1:       b = CHAR_PLUS;
          2:       b = CHAR_MINUS;
          3:       b = CHAR_SPACE;
          default: b = 8'(CHAR_ZERO + $urandom_range(0, 9));
        endcase
        text_q.push_back(b);
      end
    end
    flush_text();
  endtask

  initial begin
    int unsigned start;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    send_text("29.2.2000");
    send_text("29.2.1900");
    send_text("28.2.1900");
    send_text("31.12.65535");
    send_text("1.1.1");
    send_text(".1.2000");
    send_text("1.1.0");
    send_text("+5.+3.2000");
    send_text("5.-3.2000");
    send_text(" \t7.\n8.\r2020x9");
    send_text("1.2.3.4");
    send_text("1.2");
    send_text("");
    send_text("70000.1.2000");
    send_text("1.1.99999");
    send_text("31.4.2000");
    send_text("32.1.2000");
    send_text("1.13.2000");
    send_text("+.1.2000");
    send_text("5a.6.2001");
    send_text("\377\200.1.1");

    // hold off until the directed results are all back
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);

    start = n_sent;
    while (n_sent - start < RandChars) begin
      if (n_sent - start >= RandChars - TailChars) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      send_random_date();
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
